[rtl/assert_macros.svh]
// Assertion macros used by the checker file.
// Each macro runs on the rising edge of clk and stays quiet while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an expression holds at every clock edge.
`define ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/iup_pkg.sv]
// ----------------------------------------------------------------------------
// iup_pkg
// Constants, codes and interface structs of the image packetizer.
// ----------------------------------------------------------------------------
package iup_pkg;

    // Chunk payload limit; a power of two so that packet counting is a shift.
    localparam int MAX_PAYLOAD        = 1024;
    localparam int PAD_BYTES          = 0;
    localparam int IMAGE_HEADER_BYTES = 10;

    localparam int PKT_HDR_BYTES = 20;
    localparam logic [31:0] PKT_MAGIC     = 32'hAAAA5555;
    localparam logic [7:0]  CHANNELS_MONO = 8'd1;
    localparam logic [7:0]  DEPTH_BITS    = 8'd8;

    localparam int PAYLOAD_LOG2 = $clog2(MAX_PAYLOAD);
    localparam int FILL_W       = $clog2(MAX_PAYLOAD + 1);
    localparam int COUNT_W      = 24;
    localparam int ENC_W        = 25;
    localparam int SEQ_W        = 20;
    localparam int CNT_W        = $clog2(PKT_HDR_BYTES);
    localparam int PAD_LAST     = (PAD_BYTES == 0) ? 0 : PAD_BYTES - 1;

    localparam int IN_W = 64;

    // Input item kinds carried on s_tuser
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_DATA  = 1'b1;

    typedef enum logic [1:0] {
        SEL_DATA = 2'd0,
        SEL_HDR  = 2'd1,
        SEL_IMG  = 2'd2,
        SEL_PAD  = 2'd3
    } byte_sel_t;

    typedef struct packed {
        logic      load_start;
        logic      take_data;
        logic      emit;
        byte_sel_t sel;
        logic      eop;
        logic      eoi;
        logic      last;
        logic      cnt_clr;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
        logic frame_open;
        logic chunk_end;
        logic image_end;
        logic empty_start;
        logic hdr_done;
        logic img_done;
        logic pad_done;
    } dp_status_t;

endpackage

[rtl/iup_ctrl.sv]
// ----------------------------------------------------------------------------
// iup_ctrl
// Sequencer: accepts requests, passes data bytes on and steps through the
// header, image header and padding phases, one output byte per free output slot.
// ----------------------------------------------------------------------------
module iup_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    input  logic                s_kind,
    output logic                s_tready,
    input  iup_pkg::dp_status_t status,
    output iup_pkg::dp_cmd_t    cmd
);
    import iup_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE      = 5'b00001,
        ST_HDR_FIRST = 5'b00010,
        ST_IMG       = 5'b00100,
        ST_HDR       = 5'b01000,
        ST_PAD       = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign s_tready = (state_reg == ST_IDLE) && status.out_free;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        state_next     = state_reg;
        cmd.load_start = 1'b0;
        cmd.take_data  = 1'b0;
        cmd.emit       = 1'b0;
        cmd.sel        = SEL_DATA;
        cmd.eop        = 1'b0;
        cmd.eoi        = 1'b0;
        cmd.last       = 1'b0;
        cmd.cnt_clr    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.cnt_clr = 1'b1;
                    if (s_kind == CMD_START)
                    begin
                        cmd.load_start = 1'b1;
                        if (!status.empty_start)
                        begin
                            state_next = ST_HDR_FIRST;
                        end
                    end
                    else if (status.frame_open)
                    begin
                        // pass the data byte straight into the output register
                        cmd.take_data = 1'b1;
                        cmd.emit      = 1'b1;
                        cmd.sel       = SEL_DATA;
                        cmd.eop       = status.chunk_end && (PAD_BYTES == 0);
                        cmd.eoi       = status.chunk_end && (PAD_BYTES == 0)
                                        && status.image_end;
                        cmd.last      = !status.chunk_end
                                        || ((PAD_BYTES == 0) && status.image_end);
                        if (status.chunk_end)
                        begin
                            if (PAD_BYTES != 0)
                            begin
                                state_next = ST_PAD;
                            end
                            else if (!status.image_end)
                            begin
                                state_next = ST_HDR;
                            end
                        end
                    end
                end
            end
            ST_HDR_FIRST:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    cmd.sel  = SEL_HDR;
                    if (status.hdr_done)
                    begin
                        cmd.cnt_clr = 1'b1;
                        state_next  = ST_IMG;
                    end
                end
            end
            ST_IMG:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    cmd.sel  = SEL_IMG;
                    if (status.img_done)
                    begin
                        cmd.last    = 1'b1;
                        cmd.cnt_clr = 1'b1;
                        state_next  = ST_IDLE;
                    end
                end
            end
            ST_HDR:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    cmd.sel  = SEL_HDR;
                    if (status.hdr_done)
                    begin
                        cmd.last    = 1'b1;
                        cmd.cnt_clr = 1'b1;
                        state_next  = ST_IDLE;
                    end
                end
            end
            ST_PAD:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    cmd.sel  = SEL_PAD;
                    if (status.pad_done)
                    begin
                        // frame already closed when the image ended on this chunk
                        cmd.eop     = 1'b1;
                        cmd.eoi     = !status.frame_open;
                        cmd.last    = !status.frame_open;
                        cmd.cnt_clr = 1'b1;
                        state_next  = status.frame_open ? ST_HDR : ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[rtl/iup_datapath.sv]
// ----------------------------------------------------------------------------
// iup_datapath
// Image and chunk bookkeeping, header byte selection and the output register.
// ----------------------------------------------------------------------------
module iup_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [iup_pkg::IN_W-1:0]    s_tdata,
    input  iup_pkg::dp_cmd_t            cmd,
    output iup_pkg::dp_status_t         status,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [7:0]                  m_tdata,
    output logic                        m_tlast,
    output logic [1:0]                  m_tuser
);
    import iup_pkg::*;

    logic [7:0]         in_pixel;
    logic [15:0]        in_width;
    logic [15:0]        in_height;
    logic [COUNT_W-1:0] in_count;
    logic [ENC_W-1:0]   in_enc;
    logic [ENC_W:0]     in_round;

    logic               frame_open_reg, frame_open_next;
    logic [COUNT_W-1:0] bytes_left_reg, bytes_left_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic [SEQ_W-1:0]   seq_reg, seq_next;
    logic [SEQ_W-1:0]   total_reg, total_next;
    logic [ENC_W-1:0]   enc_len_reg, enc_len_next;
    logic [ENC_W-1:0]   enc_left_reg, enc_left_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [15:0]        width_reg;
    logic [15:0]        height_reg;

    logic               out_valid_reg, out_valid_next;
    logic [7:0]         out_byte_reg;
    logic               out_eop_reg;
    logic               out_eoi_reg;
    logic               out_last_reg;

    logic [FILL_W-1:0]  chunk_size;
    logic [31:0]        hdr_word;
    logic [31:0]        enc_word;
    logic [7:0]         hdr_byte;
    logic [7:0]         img_byte;
    logic [7:0]         sel_byte;

    assign in_pixel  = s_tdata[7:0];
    assign in_width  = s_tdata[23:8];
    assign in_height = s_tdata[39:24];
    assign in_count  = s_tdata[63:40];
    assign in_enc    = {1'b0, in_count} + ENC_W'(IMAGE_HEADER_BYTES);
    assign in_round  = {1'b0, in_enc} + (ENC_W + 1)'(MAX_PAYLOAD - 1);

    // size of the chunk carried by the current sequence number
    assign chunk_size = (enc_left_reg >= ENC_W'(MAX_PAYLOAD))
                        ? FILL_W'(MAX_PAYLOAD) : enc_left_reg[FILL_W-1:0];

    assign status.out_free    = !out_valid_reg || m_tready;
    assign status.frame_open  = frame_open_reg;
    assign status.chunk_end   = (fill_reg + FILL_W'(1)) >= chunk_size;
    assign status.image_end   = (bytes_left_reg == COUNT_W'(1));
    assign status.empty_start = (in_count == '0);
    assign status.hdr_done    = (cnt_reg == CNT_W'(PKT_HDR_BYTES - 1));
    assign status.img_done    = (cnt_reg == CNT_W'(IMAGE_HEADER_BYTES - 1));
    assign status.pad_done    = (cnt_reg == CNT_W'(PAD_LAST));

    assign enc_word = {{(32 - ENC_W){1'b0}}, enc_len_reg};

    always_comb
    begin
        case (cnt_reg[CNT_W-1:2])
            3'd0:    hdr_word = PKT_MAGIC;
            3'd1:    hdr_word = {{(32 - SEQ_W){1'b0}}, total_reg};
            3'd2:    hdr_word = enc_word;
            3'd3:    hdr_word = {{(32 - SEQ_W){1'b0}}, seq_reg};
            3'd4:    hdr_word = {{(32 - FILL_W){1'b0}}, chunk_size};
            default: hdr_word = '0;
        endcase
        // little-endian words
        hdr_byte = hdr_word[{cnt_reg[1:0], 3'b000} +: 8];
    end

    always_comb
    begin
        case (cnt_reg)
            CNT_W'(0): img_byte = enc_word[31:24];
            CNT_W'(1): img_byte = enc_word[23:16];
            CNT_W'(2): img_byte = enc_word[15:8];
            CNT_W'(3): img_byte = enc_word[7:0];
            CNT_W'(4): img_byte = width_reg[15:8];
            CNT_W'(5): img_byte = width_reg[7:0];
            CNT_W'(6): img_byte = height_reg[15:8];
            CNT_W'(7): img_byte = height_reg[7:0];
            CNT_W'(8): img_byte = CHANNELS_MONO;
            CNT_W'(9): img_byte = DEPTH_BITS;
            default:   img_byte = 8'h00;
        endcase
    end

    always_comb
    begin
        case (cmd.sel)
            SEL_DATA: sel_byte = in_pixel;
            SEL_HDR:  sel_byte = hdr_byte;
            SEL_IMG:  sel_byte = img_byte;
            SEL_PAD:  sel_byte = 8'h00;
            default:  sel_byte = 8'h00;
        endcase
    end

    always_comb
    begin
        frame_open_next = frame_open_reg;
        bytes_left_next = bytes_left_reg;
        fill_next       = fill_reg;
        seq_next        = seq_reg;
        total_next      = total_reg;
        enc_len_next    = enc_len_reg;
        enc_left_next   = enc_left_reg;
        if (cmd.load_start)
        begin
            // a new start abandons whatever image is open
            frame_open_next = !status.empty_start;
            bytes_left_next = in_count;
            fill_next       = status.empty_start ? '0 : FILL_W'(IMAGE_HEADER_BYTES);
            seq_next        = SEQ_W'(1);
            enc_len_next    = status.empty_start ? '0 : in_enc;
            enc_left_next   = status.empty_start ? '0 : in_enc;
            total_next      = status.empty_start ? '0
                              : SEQ_W'(in_round[ENC_W:PAYLOAD_LOG2]);
        end
        else if (cmd.take_data)
        begin
            bytes_left_next = bytes_left_reg - COUNT_W'(1);
            if (status.chunk_end)
            begin
                fill_next = '0;
                if (status.image_end)
                begin
                    frame_open_next = 1'b0;
                end
                else
                begin
                    seq_next      = seq_reg + SEQ_W'(1);
                    enc_left_next = enc_left_reg - ENC_W'(MAX_PAYLOAD);
                end
            end
            else
            begin
                fill_next = fill_reg + FILL_W'(1);
            end
        end
    end

    always_comb
    begin
        if (cmd.cnt_clr)
        begin
            cnt_next = '0;
        end
        else if (cmd.emit)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else
        begin
            cnt_next = cnt_reg;
        end
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_open_reg <= 1'b0;
            bytes_left_reg <= '0;
            fill_reg       <= '0;
            seq_reg        <= SEQ_W'(1);
            total_reg      <= '0;
            enc_len_reg    <= '0;
            enc_left_reg   <= '0;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            frame_open_reg <= frame_open_next;
            bytes_left_reg <= bytes_left_next;
            fill_reg       <= fill_next;
            seq_reg        <= seq_next;
            total_reg      <= total_next;
            enc_len_reg    <= enc_len_next;
            enc_left_reg   <= enc_left_next;
            cnt_reg        <= cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_start)
        begin
            width_reg  <= in_width;
            height_reg <= in_height;
        end
        if (cmd.emit)
        begin
            out_byte_reg <= sel_byte;
            out_eop_reg  <= cmd.eop;
            out_eoi_reg  <= cmd.eoi;
            out_last_reg <= cmd.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_eop_reg;
    assign m_tuser  = {out_last_reg, out_eoi_reg};

endmodule

[rtl/image_udp_packetizer_unit.sv]
// ----------------------------------------------------------------------------
// image_udp_packetizer_unit
// Mono 8-bit image to packet byte stream with image and chunk headers.
// ----------------------------------------------------------------------------
// A start request carries width, height and data byte count; once it is taken,
// 20 packet header bytes and the image header bytes leave one per cycle while
// the output is not stalled, with s_tready low meanwhile. A data byte that does
// not close a chunk goes straight to the output register. A data byte that
// closes a chunk adds the padding bytes and, if data remains, the next 20-byte
// header. The single output register moves one byte per cycle when not stalled;
// s_tready also drops while an output byte waits. Data with no open image is
// taken and dropped; a start with a zero count produces no output. MAX_PAYLOAD
// is a power of two.
module image_udp_packetizer_unit (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // pixel_byte[7:0], image_width[23:8], image_height[39:24], image_bytes[63:40]
    input  logic [iup_pkg::IN_W-1:0] s_tdata,
    // cmd
    input  logic                     s_tuser,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // out_byte
    output logic [7:0]               m_tdata,
    output logic                     m_tlast,
    // end_of_image[0], last[1]
    output logic [1:0]               m_tuser
);
    import iup_pkg::*;

    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;

    iup_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_kind   (s_tuser),
        .s_tready (s_tready),
        .status   (dp_status),
        .cmd      (dp_cmd)
    );

    iup_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .cmd      (dp_cmd),
        .status   (dp_status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

[rtl/iup_checker.sv]
// ----------------------------------------------------------------------------
// iup_checker
// Port-level checks on the packetizer, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module iup_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic        m_tlast,
    input logic [1:0]  m_tuser
);

    // hold a stalled output byte
    `ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser), "stalled output changed")

    // no request taken while an output byte still waits
    `ASSERT_IMPL(a_no_accept_stalled, s_tvalid && s_tready, !(m_tvalid && !m_tready), "request taken over a waiting output")

    // end of image closes a packet
    `ASSERT_IMPL(a_eoi_eop, m_tvalid && m_tuser[0], m_tlast, "end of image without end of packet")

    // end of image is the last byte of its request
    `ASSERT_IMPL(a_eoi_last, m_tvalid && m_tuser[0], m_tuser[1], "end of image not last of request")

endmodule

bind image_udp_packetizer_unit iup_checker u_iup_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
